// File: hdl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types and constants shared by the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_AW    = 12;
	localparam int CNT_W      = 13;
	localparam int REF_WIDTH  = 16;
	localparam int FLAG_WIDTH = 8;

	localparam logic [FLAG_WIDTH-1:0] RESERVED_FLAG = FLAG_WIDTH'(8'h08);
	localparam logic [REF_WIDTH-1:0]  REF_MAX       = {REF_WIDTH{1'b1}};

	localparam logic [2:0] MODE_ALLOC     = 3'd0;
	localparam logic [2:0] MODE_FREE_REF  = 3'd1;
	localparam logic [2:0] MODE_FREE_REG  = 3'd2;
	localparam logic [2:0] MODE_RESERVE   = 3'd3;
	localparam logic [2:0] MODE_REF       = 3'd4;
	localparam logic [2:0] MODE_SET_FLAGS = 3'd5;
	localparam logic [2:0] MODE_CLR_FLAGS = 3'd6;
	localparam logic [2:0] MODE_QUERY     = 3'd7;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam logic [2:0] REG_PAGE_LIMIT = 3'd0;

	typedef struct packed {
		logic [2:0]       mode;
		logic [11:0]      page_index;
		logic [12:0]      num_pages;
		logic [7:0]       flag_bits;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [11:0]      result_page;
		logic [15:0]      ref_cnt;
		logic [7:0]       page_flags;
		logic [12:0]      free_count;
		logic [12:0]      used_count;
	} out_item_t;

	typedef struct packed {
		logic                  used;
		logic [REF_WIDTH-1:0]  refs;
		logic [FLAG_WIDTH-1:0] flags;
	} page_entry_t;

	typedef struct packed {
		logic               rd_en;
		logic [PAGE_AW-1:0] rd_addr;
		logic               wr_en;
		logic [PAGE_AW-1:0] wr_addr;
		page_entry_t        wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_FILL,
		ST_FIN_RD,
		ST_DONE
	} state_t;

endpackage

// File: hdl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page-frame allocator with per-page refcount and flags.
// ----------------------------------------------------------------------------
// Out-of-range requests and zero-count allocations go straight to the result;
// queries and zero-count run requests read the base page; other modes do a
// registered read and a write-back per page, then read the base page; allocation
// scans for a fit and on a hit fills the run and reads its first page. One request
// at a time; a held result delays the next. After reset each entry is set used
// before the first request is taken; the register port works meanwhile.
module bitmap_page_frame_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bpfa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bpfa_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [12:0]           page_limit_q;
	logic [12:0]           lim;
	bpfa_pkg::mem_req_t    mem_req;
	bpfa_pkg::page_entry_t rd_data;

	assign pready = 1'b1;
	assign prdata = (paddr == bpfa_pkg::REG_PAGE_LIMIT) ? {19'd0, page_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= 13'(bpfa_pkg::MAX_PAGES);
		end else if (psel && penable && pwrite && !paddr[2]) begin
			page_limit_q <= pwdata[12:0];
		end
	end

	assign lim = (page_limit_q < 13'(bpfa_pkg::MAX_PAGES)) ? page_limit_q :
		13'(bpfa_pkg::MAX_PAGES);

	bpfa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.lim       (lim),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	bpfa_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while a previous one is in progress");

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.free_count <= 13'(bpfa_pkg::MAX_PAGES)))
		else $error("free count beyond table size");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in progress");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall) |-> !mem_req.wr_en)
		else $error("page table written while idle");

endmodule

// File: hdl/bpfa_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_mem
// Page table memory: used bit, refcount and flags per page, one read and
// one write port, registered read data.
// ----------------------------------------------------------------------------
module bpfa_mem (
	input  logic                  clk,
	input  bpfa_pkg::mem_req_t    req,
	output bpfa_pkg::page_entry_t rd_data
);

	bpfa_pkg::page_entry_t mem [bpfa_pkg::MAX_PAGES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// File: hdl/bpfa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_seq
// Request sequencer: walks the page table one entry at a time, does the
// read-modify-write for each mode, keeps the free count and holds the result.
// ----------------------------------------------------------------------------
module bpfa_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [12:0]           lim,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  bpfa_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bpfa_pkg::out_item_t   out_data,
	output bpfa_pkg::mem_req_t    mem_req,
	input  bpfa_pkg::page_entry_t rd_data
);

	localparam int REF_W = bpfa_pkg::REF_WIDTH;

	bpfa_pkg::state_t      state_q, state_nxt;
	logic [2:0]            mode_q;
	logic [11:0]           base_q;
	logic [12:0]           count_q;
	logic [7:0]            fl_q;
	logic [12:0]           cur_q;
	logic [12:0]           end_q;
	logic [12:0]           run_q;
	logic [1:0]            status_q;
	logic                  zero_q;
	logic [12:0]           free_q;
	logic                  out_valid_q;
	bpfa_pkg::out_item_t   out_q;

	logic                  acc;
	logic                  alloc_bad;
	logic                  out_range;
	logic                  zero_cnt;
	logic [13:0]           run_end;
	logic [12:0]           walk_end;
	logic [12:0]           cur_inc;
	logic [12:0]           run_inc;
	logic                  hit;
	logic                  scan_last;
	logic                  load_out;
	logic [REF_W-1:0]      ref_dec;
	bpfa_pkg::page_entry_t new_entry;
	logic                  free_up;
	logic                  free_dn;

	assign acc       = (state_q == bpfa_pkg::ST_IDLE) && in_valid;
	assign in_stall  = (state_q != bpfa_pkg::ST_IDLE);
	assign alloc_bad = (in_data.num_pages == 13'd0) || (lim == 13'd0);
	assign out_range = ({1'b0, in_data.page_index} >= lim);
	assign zero_cnt  = (in_data.mode <= bpfa_pkg::MODE_RESERVE) &&
		(in_data.num_pages == 13'd0);
	assign run_end   = {2'b00, in_data.page_index} + {1'b0, in_data.num_pages};
	assign walk_end  = (run_end > {1'b0, lim}) ? lim : run_end[12:0];
	assign cur_inc   = cur_q + 13'd1;
	assign run_inc   = run_q + 13'd1;
	assign hit       = !rd_data.used && (run_inc == count_q);
	assign scan_last = (cur_inc == lim);
	assign load_out  = (state_q == bpfa_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign ref_dec   = (rd_data.refs != '0) ? rd_data.refs - REF_W'(1) : rd_data.refs;

	// Per-page update for the run and single-page modes.
	always_comb begin
		new_entry = rd_data;
		free_up   = 1'b0;
		free_dn   = 1'b0;
		case (mode_q)
			bpfa_pkg::MODE_FREE_REF: begin
				if (rd_data.used) begin
					new_entry.refs = ref_dec;
					if (ref_dec == '0) begin
						new_entry.used  = 1'b0;
						new_entry.flags = '0;
						free_up         = 1'b1;
					end
				end
			end
			bpfa_pkg::MODE_FREE_REG: begin
				if (rd_data.used) begin
					new_entry.used = 1'b0;
					free_up        = 1'b1;
				end
			end
			bpfa_pkg::MODE_RESERVE: begin
				if (!rd_data.used) begin
					free_dn = 1'b1;
				end
				new_entry.used  = 1'b1;
				new_entry.flags = rd_data.flags | bpfa_pkg::RESERVED_FLAG;
			end
			bpfa_pkg::MODE_REF: begin
				if (rd_data.refs != bpfa_pkg::REF_MAX) begin
					new_entry.refs = rd_data.refs + REF_W'(1);
				end
			end
			bpfa_pkg::MODE_SET_FLAGS: new_entry.flags = rd_data.flags | fl_q;
			bpfa_pkg::MODE_CLR_FLAGS: new_entry.flags = rd_data.flags & ~fl_q;
			default: ;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bpfa_pkg::ST_CLEAR: begin
				if (cur_q[11:0] == {bpfa_pkg::PAGE_AW{1'b1}}) begin
					state_nxt = bpfa_pkg::ST_IDLE;
				end
			end
			bpfa_pkg::ST_IDLE: begin
				if (acc) begin
					if (in_data.mode == bpfa_pkg::MODE_ALLOC) begin
						state_nxt = alloc_bad ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_RD;
					end else if (out_range) begin
						state_nxt = bpfa_pkg::ST_DONE;
					end else if (zero_cnt || in_data.mode == bpfa_pkg::MODE_QUERY) begin
						state_nxt = bpfa_pkg::ST_FIN_RD;
					end else begin
						state_nxt = bpfa_pkg::ST_RD;
					end
				end
			end
			bpfa_pkg::ST_RD: state_nxt = bpfa_pkg::ST_EV;
			bpfa_pkg::ST_EV: begin
				if (mode_q == bpfa_pkg::MODE_ALLOC) begin
					if (hit) begin
						state_nxt = bpfa_pkg::ST_FILL;
					end else if (scan_last) begin
						state_nxt = bpfa_pkg::ST_DONE;
					end else begin
						state_nxt = bpfa_pkg::ST_RD;
					end
				end else begin
					state_nxt = (cur_inc == end_q) ? bpfa_pkg::ST_FIN_RD : bpfa_pkg::ST_RD;
				end
			end
			bpfa_pkg::ST_FILL: begin
				if (cur_inc == end_q) begin
					state_nxt = bpfa_pkg::ST_FIN_RD;
				end
			end
			bpfa_pkg::ST_FIN_RD: state_nxt = bpfa_pkg::ST_DONE;
			bpfa_pkg::ST_DONE: begin
				if (load_out) begin
					state_nxt = bpfa_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bpfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req         = '0;
		mem_req.rd_addr = cur_q[11:0];
		mem_req.wr_addr = cur_q[11:0];
		mem_req.wr_data = new_entry;
		case (state_q)
			bpfa_pkg::ST_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_data = '{used: 1'b1, refs: '0, flags: '0};
			end
			bpfa_pkg::ST_RD: mem_req.rd_en = 1'b1;
			bpfa_pkg::ST_EV: mem_req.wr_en = (mode_q != bpfa_pkg::MODE_ALLOC);
			bpfa_pkg::ST_FILL: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_data = '{used: 1'b1, refs: REF_W'(1), flags: '0};
			end
			bpfa_pkg::ST_FIN_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = base_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::ST_CLEAR;
			cur_q       <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bpfa_pkg::ST_CLEAR: cur_q <= cur_inc;
				bpfa_pkg::ST_IDLE: begin
					if (acc) begin
						cur_q <= {1'b0, in_data.page_index};
						end_q <= (in_data.mode <= bpfa_pkg::MODE_RESERVE) ? walk_end :
							{1'b0, in_data.page_index} + 13'd1;
						if (in_data.mode == bpfa_pkg::MODE_ALLOC) begin
							cur_q <= '0;
						end
					end
				end
				bpfa_pkg::ST_EV: begin
					cur_q <= cur_inc;
					if (mode_q == bpfa_pkg::MODE_ALLOC) begin
						if (hit) begin
							cur_q  <= cur_inc - count_q;
							end_q  <= cur_inc;
							free_q <= free_q - count_q;
						end
					end else if (free_up) begin
						free_q <= free_q + 13'd1;
					end else if (free_dn) begin
						free_q <= free_q - 13'd1;
					end
				end
				bpfa_pkg::ST_FILL: cur_q <= cur_inc;
				default: ;
			endcase
		end
	end

	// Request context and result payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q   <= in_data.mode;
			base_q   <= in_data.page_index;
			count_q  <= in_data.num_pages;
			fl_q     <= in_data.flag_bits;
			run_q    <= '0;
			status_q <= bpfa_pkg::STATUS_DONE;
			zero_q   <= 1'b0;
			if (in_data.mode == bpfa_pkg::MODE_ALLOC) begin
				base_q <= '0;
				if (alloc_bad) begin
					status_q <= bpfa_pkg::STATUS_FAIL;
					zero_q   <= 1'b1;
				end
			end else if (out_range) begin
				status_q <= bpfa_pkg::STATUS_RANGE;
				zero_q   <= 1'b1;
			end else if (zero_cnt) begin
				status_q <= bpfa_pkg::STATUS_FAIL;
			end
		end
		if (state_q == bpfa_pkg::ST_EV && mode_q == bpfa_pkg::MODE_ALLOC) begin
			run_q <= rd_data.used ? 13'd0 : run_inc;
			if (hit) begin
				base_q <= 12'(cur_inc - count_q);
			end else if (scan_last) begin
				status_q <= bpfa_pkg::STATUS_FAIL;
				zero_q   <= 1'b1;
			end
		end
		if (load_out) begin
			out_q.status      <= status_q;
			out_q.result_page <= base_q;
			out_q.ref_cnt     <= zero_q ? 16'd0 : 16'(rd_data.refs);
			out_q.page_flags  <= zero_q ? 8'd0 : 8'(rd_data.flags);
			out_q.free_count  <= free_q;
			out_q.used_count  <= (lim > free_q) ? lim - free_q : 13'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the bitmap page-frame allocator. A behavioral copy of the
// page table predicts each result as its request is accepted. Directed tests
// cover reset state, every mode, range and zero-count cases, refcount climbs
// and limit changes; random phases then run mixed traffic under several
// page limits, with both sides stalling at random in all but the last.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 20000000;
	localparam int NPAGES      = bpfa_pkg::MAX_PAGES;
	localparam int REF_W       = bpfa_pkg::REF_WIDTH;
	localparam int FLAG_W      = bpfa_pkg::FLAG_WIDTH;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	bpfa_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	bpfa_pkg::out_item_t out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	bitmap_page_frame_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// Shadow page table.
	bit                page_used [NPAGES];
	logic [REF_W-1:0]  page_refcnt [NPAGES];
	logic [FLAG_W-1:0] page_flagv [NPAGES];
	int                pages_free;
	logic [12:0]       limit_reg;

	bpfa_pkg::out_item_t expected_results [$];
	int        live_starts [$];
	int        live_counts [$];
	int        failures = 0;
	int        results_checked = 0;
	int        config_writes = 0;
	int        cycles = 0;
	bit        idle_on = 1'b1;

	function automatic int page_limit();
		return (limit_reg < NPAGES) ? int'(limit_reg) : NPAGES;
	endfunction

	function automatic bpfa_pkg::out_item_t predict_allocator(bpfa_pkg::in_item_t req);
		bpfa_pkg::out_item_t res;
		int lim, run, start, k, p;
		bit found, show;
		lim = page_limit();
		res = '0;
		res.result_page = req.page_index;
		show = 1'b1;
		found = 1'b0;
		start = 0;
		if (req.mode == bpfa_pkg::MODE_ALLOC) begin
			run = 0;
			if (req.num_pages != 0) begin
				for (k = 0; k < lim && !found; k++) begin
					if (page_used[k]) run = 0;
					else begin
						run++;
						if (run == req.num_pages) begin
							start = k + 1 - run;
							found = 1'b1;
						end
					end
				end
			end
			if (found) begin
				for (k = start; k < start + req.num_pages; k++) begin
					if (!page_used[k]) pages_free--;
					page_used[k] = 1'b1;
					page_refcnt[k] = REF_W'(1);
					page_flagv[k] = '0;
				end
				res.result_page = 12'(start);
			end else begin
				res.status = bpfa_pkg::STATUS_FAIL;
				res.result_page = '0;
				show = 1'b0;
			end
		end else if (req.page_index >= lim) begin
			res.status = bpfa_pkg::STATUS_RANGE;
			show = 1'b0;
		end else if (req.mode <= bpfa_pkg::MODE_RESERVE && req.num_pages == 0) begin
			res.status = bpfa_pkg::STATUS_FAIL;
		end else begin
			for (k = 0; k < req.num_pages && req.mode <= bpfa_pkg::MODE_RESERVE; k++) begin
				p = req.page_index + k;
				if (p >= lim) break;
				case (req.mode)
					bpfa_pkg::MODE_FREE_REF: begin
						if (page_used[p]) begin
							if (page_refcnt[p] > 0) page_refcnt[p]--;
							if (page_refcnt[p] == 0) begin
								page_used[p] = 1'b0;
								pages_free++;
								page_flagv[p] = '0;
							end
						end
					end
					bpfa_pkg::MODE_FREE_REG: begin
						if (page_used[p]) pages_free++;
						page_used[p] = 1'b0;
					end
					default: begin
						if (!page_used[p]) pages_free--;
						page_used[p] = 1'b1;
						page_flagv[p] |= bpfa_pkg::RESERVED_FLAG;
					end
				endcase
			end
			p = req.page_index;
			case (req.mode)
				bpfa_pkg::MODE_REF:
					if (page_refcnt[p] != bpfa_pkg::REF_MAX) page_refcnt[p]++;
				bpfa_pkg::MODE_SET_FLAGS: page_flagv[p] |= req.flag_bits;
				bpfa_pkg::MODE_CLR_FLAGS: page_flagv[p] &= ~req.flag_bits;
				default: ;
			endcase
		end
		if (show && res.result_page < lim) begin
			res.ref_cnt = page_refcnt[res.result_page];
			res.page_flags = page_flagv[res.result_page];
		end
		res.free_count = 13'(pages_free);
		res.used_count = (lim > pages_free) ? 13'(lim - pages_free) : 13'd0;
		if (req.mode == bpfa_pkg::MODE_ALLOC && found) begin
			live_starts.push_back(start);
			live_counts.push_back(int'(req.num_pages));
		end
		return res;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(logic [2:0] mode, int idx, int cnt, int flg);
		bpfa_pkg::in_item_t req;
		req.mode = mode;
		req.page_index = 12'(idx);
		req.num_pages = 13'(cnt);
		req.flag_bits = 8'(flg);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_data = req;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_allocator(req));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit_reg(int value);
		wait_drained();
		psel = 1'b1; pwrite = 1'b1;
		paddr = 3'(bpfa_pkg::REG_PAGE_LIMIT) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		@(negedge clk);
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[12:0] !== 13'(value))
			$error("page limit readback: expected %0d actual %0d", 13'(value), prdata[12:0]);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
		limit_reg = 13'(value);
		config_writes++;
	endtask

	task automatic check_field(string name, int expv, int act);
		if (expv !== act) begin
			$error("%s mismatch: expected %0d actual %0d", name, expv, act);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bitmap_page_frame_allocator regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		bpfa_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no request outstanding");
				failures++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("status", want.status, out_data.status);
				check_field("result_page", want.result_page, out_data.result_page);
				check_field("ref_cnt", want.ref_cnt, out_data.ref_cnt);
				check_field("page_flags", want.page_flags, out_data.page_flags);
				check_field("free_count", want.free_count, out_data.free_count);
				check_field("used_count", want.used_count, out_data.used_count);
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else
				out_stall = 1'b0;
		end
	end

	task automatic test_reset_state();
		send_request(bpfa_pkg::MODE_QUERY, 0, 0, 0);
		send_request(bpfa_pkg::MODE_QUERY, 4095, 4096, 8'hFF);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 1, 0);
		send_request(bpfa_pkg::MODE_FREE_REF, 4095, 1, 0);
	endtask

	task automatic test_every_mode();
		write_limit_reg(16);
		send_request(bpfa_pkg::MODE_FREE_REG, 0, 0, 0);
		send_request(bpfa_pkg::MODE_FREE_REG, 2, 4096, 0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 0, 0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 15, 0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 4, 0);
		send_request(bpfa_pkg::MODE_REF, 2, 0, 0);
		send_request(bpfa_pkg::MODE_SET_FLAGS, 2, 0, 8'hFF);
		send_request(bpfa_pkg::MODE_CLR_FLAGS, 2, 0, 8'h0F);
		send_request(bpfa_pkg::MODE_FREE_REF, 2, 2, 0);
		send_request(bpfa_pkg::MODE_FREE_REF, 2, 2, 0);
		send_request(bpfa_pkg::MODE_FREE_REF, 2, 1, 0);
		send_request(bpfa_pkg::MODE_RESERVE, 12, 4096, 0);
		send_request(bpfa_pkg::MODE_RESERVE, 0, 1, 0);
		send_request(bpfa_pkg::MODE_FREE_REF, 0, 1, 0);
		send_request(bpfa_pkg::MODE_QUERY, 4095, 0, 0);
		send_request(bpfa_pkg::MODE_SET_FLAGS, 16, 0, 8'h01);
		send_request(bpfa_pkg::MODE_ALLOC, 4095, 4096, 8'hFF);
	endtask

	task automatic test_limit_changes();
		write_limit_reg(64);
		send_request(bpfa_pkg::MODE_FREE_REG, 0, 64, 0);
		write_limit_reg(8);
		send_request(bpfa_pkg::MODE_QUERY, 7, 0, 0);
		write_limit_reg(0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 1, 0);
		send_request(bpfa_pkg::MODE_QUERY, 0, 0, 0);
		write_limit_reg(8191);
		send_request(bpfa_pkg::MODE_FREE_REG, 0, 4096, 0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 4096, 0);
		send_request(bpfa_pkg::MODE_QUERY, 4095, 0, 0);
		send_request(bpfa_pkg::MODE_FREE_REG, 4000, 200, 0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 96, 0);
		write_limit_reg(4096);
		send_request(bpfa_pkg::MODE_RESERVE, 0, 4096, 0);
	endtask

	task automatic test_refcount_climb();
		int n;
		idle_on = 1'b0;
		write_limit_reg(16);
		send_request(bpfa_pkg::MODE_FREE_REG, 0, 16, 0);
		send_request(bpfa_pkg::MODE_ALLOC, 0, 1, 0);
		for (n = 0; n < 40; n++) send_request(bpfa_pkg::MODE_REF, 0, 0, 0);
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(int limit, int items);
		int n, sel, lim, slot, idx;
		write_limit_reg(limit);
		lim = page_limit();
		live_starts.delete();
		live_counts.delete();
		send_request(bpfa_pkg::MODE_FREE_REG, 0, lim, 0);
		for (n = 0; n < items; n++) begin
			sel = $urandom_range(0, 99);
			idx = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
			if (sel < 25)
				send_request(bpfa_pkg::MODE_ALLOC, $urandom_range(0, 4095),
					$urandom_range(1, 8), $urandom_range(0, 255));
			else if (sel < 45 && live_starts.size() != 0) begin
				slot = $urandom_range(0, live_starts.size() - 1);
				send_request(bpfa_pkg::MODE_FREE_REF, live_starts[slot], live_counts[slot], 0);
				if ($urandom_range(0, 1)) begin
					live_starts.delete(slot);
					live_counts.delete(slot);
				end
			end else if (sel < 55 && live_starts.size() != 0)
				send_request(bpfa_pkg::MODE_REF,
					live_starts[$urandom_range(0, live_starts.size() - 1)],
					$urandom_range(0, 8191), 0);
			else if (sel < 70)
				send_request(3'($urandom_range(bpfa_pkg::MODE_SET_FLAGS, bpfa_pkg::MODE_QUERY)),
					idx, $urandom_range(0, 4096), $urandom_range(0, 255));
			else if (sel < 85)
				send_request(3'($urandom_range(bpfa_pkg::MODE_FREE_REG, bpfa_pkg::MODE_RESERVE)),
					idx, $urandom_range(0, 12), 0);
			else if (sel < 88)
				send_request(bpfa_pkg::MODE_FREE_REG, idx, 4096, 0);
			else
				send_request(3'($urandom_range(0, 7)), $urandom_range(0, 4095),
					$urandom_range(0, 4096), $urandom_range(0, 255));
		end
	endtask

	initial begin
		int k;
		for (k = 0; k < NPAGES; k++) begin
			page_used[k] = 1'b1;
			page_refcnt[k] = '0;
			page_flagv[k] = '0;
		end
		pages_free = 0;
		limit_reg = 13'd4096;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_every_mode();
		test_limit_changes();
		test_refcount_climb();
		test_random_traffic(64, 400);
		test_random_traffic(200, 350);
		test_random_traffic(37, 350);
		test_random_traffic(4096, 60);
		idle_on = 1'b0;
		test_random_traffic(16, 400);

		while (expected_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("Checked %0d result transactions across %0d page-limit writes.",
			results_checked, config_writes);
		$display("All eight modes ran under limits from 0 up to the full table.");
		if (failures == 0)
			$display("bitmap_page_frame_allocator regression: pass");
		else
			$display("bitmap_page_frame_allocator regression: fail");
		$finish;
	end

endmodule
